/* rtl/imu_burst_read_sequencer_assert.svh */
// Assertion macros for the burst read sequencer.
`ifndef IMU_BURST_READ_SEQUENCER_ASSERT_SVH
`define IMU_BURST_READ_SEQUENCER_ASSERT_SVH
`ifndef ASSERT_OFF
`define IBRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define IBRS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IBRS_ASSERT(lbl, clk, rstn, prop, msg)
`define IBRS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/ibrs_pkg.sv */
// Types, codes and microcode table of the burst read sequencer.
package ibrs_pkg;

  localparam int NUM_AXES    = 6;
  localparam int BURST_BYTES = 14;

  localparam logic [1:0] CMD_START      = 2'd0;
  localparam logic [1:0] CMD_BUS_EVENT  = 2'd1;
  localparam logic [1:0] CMD_SET_OFFSET = 2'd2;
  localparam logic [1:0] CMD_READ_AXIS  = 2'd3;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_START   = 3'd1;
  localparam logic [2:0] EV_TX_SEL  = 3'd2;
  localparam logic [2:0] EV_TX_DONE = 3'd3;
  localparam logic [2:0] EV_RX_SEL  = 3'd4;
  localparam logic [2:0] EV_RX_BYTE = 3'd5;

  localparam logic [1:0] ACK_KEEP    = 2'd0;
  localparam logic [1:0] ACK_ENABLE  = 2'd1;
  localparam logic [1:0] ACK_DISABLE = 2'd2;

  localparam logic [2:0] AXIS_EVERY = 3'd6;

  localparam logic [4:0] STEP_IDLE     = 5'd1;
  localparam logic [4:0] STEP_FIRST_RX = 5'd6;
  localparam logic [4:0] STEP_LAST_ACK = 5'd19;

  localparam logic [6:0] DEV_ADDR_RESET  = 7'd104;
  localparam logic [7:0] FIRST_REG_RESET = 8'h3B;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_FIRST_REGISTER = 2'd1,
    CFG_INVERT_MASK    = 2'd2
  } cfg_idx_e;

  // high byte position of each axis word in the burst; temperature skipped
  localparam logic [3:0] AXIS_POS [NUM_AXES] = '{4'd0, 4'd2, 4'd4, 4'd8, 4'd10, 4'd12};

  typedef struct packed {
    logic [1:0]          cmd;
    logic [2:0]          bus_event;
    logic [7:0]          rx_byte;
    logic [2:0]          axis;
    logic signed [15:0]  offset_value;
    logic                apply_offset;
  } in_item_t;

  typedef struct packed {
    logic                send_valid;
    logic [7:0]          send_byte;
    logic                gen_start;
    logic                gen_stop;
    logic [1:0]          ack_ctrl;
    logic                bus_reset;
    logic                frame_done;
    logic signed [15:0]  read_value;
    logic                busy_res;
  } out_item_t;

  typedef struct packed {
    logic [1:0] index;
    logic [7:0] value;
  } cfg_item_t;

  typedef enum logic [1:0] {
    SEND_NONE   = 2'd0,
    SEND_ADDR_W = 2'd1,
    SEND_REG    = 2'd2,
    SEND_ADDR_R = 2'd3
  } send_sel_e;

  // one control word per step
  typedef struct packed {
    logic       in_range;
    logic [2:0] expect_ev;
    send_sel_e  send_sel;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack;
    logic       store;
    logic       finish;
    logic [4:0] next_step;
  } uop_t;

  // what the sequencer hands to the datapath for the current item
  typedef struct packed {
    send_sel_e  send_sel;
    logic       gen_start;
    logic       gen_stop;
    logic [1:0] ack;
    logic       store;
    logic [3:0] store_idx;
    logic       finish;
  } seq_ctrl_t;

  function automatic uop_t ibrs_rom(logic [4:0] step);
    uop_t u;
    u = '{in_range: 1'b1, expect_ev: EV_RX_BYTE, send_sel: SEND_NONE, gen_start: 1'b0,
          gen_stop: 1'b0, ack: ACK_KEEP, store: 1'b1, finish: 1'b0,
          next_step: 5'(step + 5'd1)};
    unique case (step)
      5'd1: begin
        u.expect_ev = EV_START;  u.send_sel = SEND_ADDR_W; u.store = 1'b0;
        u.next_step = 5'd2;
      end
      5'd2: begin
        u.expect_ev = EV_TX_SEL; u.send_sel = SEND_REG; u.store = 1'b0;
        u.next_step = 5'd3;
      end
      5'd3: begin
        u.expect_ev = EV_TX_DONE; u.gen_start = 1'b1; u.store = 1'b0;
        u.next_step = 5'd4;
      end
      5'd4: begin
        u.expect_ev = EV_START;  u.send_sel = SEND_ADDR_R; u.store = 1'b0;
        u.next_step = 5'd5;
      end
      5'd5: begin
        u.expect_ev = EV_RX_SEL; u.ack = ACK_ENABLE; u.store = 1'b0;
        u.next_step = STEP_FIRST_RX;
      end
      5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12,
      5'd13, 5'd14, 5'd15, 5'd16, 5'd17: begin
      end
      5'd18: begin
        // 13th byte: last acked one
        u.gen_stop = 1'b1; u.ack = ACK_DISABLE;
      end
      5'd19: begin
        u.finish = 1'b1; u.next_step = STEP_IDLE;
      end
      default: begin
        u.in_range = 1'b0; u.expect_ev = EV_NONE; u.store = 1'b0;
        u.next_step = STEP_IDLE;
      end
    endcase
    return u;
  endfunction

endpackage

/* rtl/ibrs_if.sv */
// Handshake channel interfaces: input items, result items, configuration writes.
interface ibrs_in_if import ibrs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ibrs_out_if import ibrs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ibrs_cfg_if import ibrs_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ibrs_seq.sv */
// Microcoded step sequencer: step counter, control ROM and event jumps.
`include "imu_burst_read_sequencer_assert.svh"
module ibrs_seq import ibrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       ev_en_i,
  input  logic [2:0] ev_i,
  output seq_ctrl_t  ctrl_o
);

  logic [4:0] step_q, step_d;
  logic [4:0] rx_off;
  uop_t       uop;
  logic       hit;
  logic       fire;

  assign uop    = ibrs_rom(step_q);
  assign hit    = uop.in_range && (ev_i == uop.expect_ev);
  assign fire   = ev_en_i && hit;
  assign rx_off = 5'(step_q - STEP_FIRST_RX);

  always_comb begin
    ctrl_o.send_sel  = fire ? uop.send_sel : SEND_NONE;
    ctrl_o.gen_start = fire && uop.gen_start;
    ctrl_o.gen_stop  = fire && uop.gen_stop;
    ctrl_o.ack       = fire ? uop.ack : ACK_KEEP;
    ctrl_o.store     = fire && uop.store;
    ctrl_o.store_idx = rx_off[3:0];
    ctrl_o.finish    = fire && uop.finish;
  end

  // mismatch holds the step, except a stray start which restarts the sequence
  always_comb begin
    step_d = step_q;
    if (ev_en_i) begin
      priority if (!uop.in_range) begin
        step_d = STEP_IDLE;
      end else if (hit) begin
        step_d = uop.next_step;
      end else if (ev_i == EV_START) begin
        step_d = STEP_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  `IBRS_ASSERT_ALWAYS(a_step_range, clk_i,
                      !rst_ni || (step_q >= STEP_IDLE && step_q <= STEP_LAST_ACK),
                      "step out of range")
  `IBRS_ASSERT(a_finish_idle, clk_i, rst_ni, ctrl_o.finish |=> step_q == STEP_IDLE,
               "finish did not return to idle")
  `IBRS_ASSERT(a_stop_last, clk_i, rst_ni, ctrl_o.gen_stop |=> step_q == STEP_LAST_ACK,
               "stop not at last byte step")

endmodule

/* rtl/ibrs_axis.sv */
// Axis sample and offset registers: frame parse, offset set, axis read.
module ibrs_axis import ibrs_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          parse_en_i,
  input  logic [BURST_BYTES-1:0][7:0]   frame_i,
  input  logic [NUM_AXES-1:0]           invert_i,
  input  logic                          set_en_i,
  input  logic [2:0]                    axis_i,
  input  logic signed [15:0]            set_value_i,
  input  logic                          apply_i,
  output logic signed [15:0]            rd_value_o
);

  logic [15:0] sample_q [NUM_AXES];
  logic [15:0] sample_d [NUM_AXES];
  logic [15:0] offset_q [NUM_AXES];
  logic [15:0] offset_d [NUM_AXES];
  logic [15:0] word     [NUM_AXES];
  logic        axis_ok;

  assign axis_ok = axis_i < 3'(NUM_AXES);

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      word[i] = {frame_i[AXIS_POS[i]], frame_i[4'(AXIS_POS[i] + 4'd1)]};
      if (invert_i[i]) begin
        word[i] = 16'(16'd0 - word[i]);
      end
      sample_d[i] = sample_q[i];
      offset_d[i] = offset_q[i];
      if (parse_en_i) begin
        sample_d[i] = word[i];
        // zero offset means capture this sample
        if (offset_q[i] == 16'd0) begin
          offset_d[i] = word[i];
        end
      end else if (set_en_i) begin
        if ((axis_ok && axis_i == 3'(i)) || axis_i == AXIS_EVERY) begin
          offset_d[i] = set_value_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sample_q[i] <= '0;
        offset_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_AXES; i++) begin
        sample_q[i] <= sample_d[i];
        offset_q[i] <= offset_d[i];
      end
    end
  end

  always_comb begin
    rd_value_o = '0;
    if (axis_ok) begin
      rd_value_o = apply_i ? 16'(sample_q[axis_i] - offset_q[axis_i]) : sample_q[axis_i];
    end
  end

endmodule

/* rtl/imu_burst_read_sequencer.sv */
// Top level: burst read sequencer for a motion sensor on a bus master.
// The result of an accepted item is in the output register next cycle.
// Throughput: one item per cycle; a new item is taken while the result register
// is empty or being drained. Each bus event item is checked against one step of the microcode ROM.
// Reset: step idle, not busy, samples and offsets zero, config registers at defaults.
// The receive byte store is not cleared; every entry is written before it is parsed.
`include "imu_burst_read_sequencer_assert.svh"
module imu_burst_read_sequencer import ibrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  ibrs_in_if.sink    in_i,
  ibrs_out_if.source out_o,
  ibrs_cfg_if.sink   cfg_i
);

  logic       accept;
  logic       out_valid_q;
  out_item_t  out_q, out_d;
  logic [6:0] dev_addr_q;
  logic [7:0] first_reg_q;
  logic [NUM_AXES-1:0] invert_q;
  logic       busy_q, busy_d;
  logic [7:0] rx_store_q [BURST_BYTES];
  logic [BURST_BYTES-1:0][7:0] frame;
  seq_ctrl_t  ctrl;
  logic       ev_en;
  logic       set_en;
  logic signed [15:0] rd_value;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign cfg_i.ready = 1'b1;

  assign ev_en  = accept && (in_i.data.cmd == CMD_BUS_EVENT);
  assign set_en = accept && (in_i.data.cmd == CMD_SET_OFFSET);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DEV_ADDR_RESET;
      first_reg_q <= FIRST_REG_RESET;
      invert_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_DEVICE_ADDRESS: dev_addr_q  <= cfg_i.data.value[6:0];
        CFG_FIRST_REGISTER: first_reg_q <= cfg_i.data.value;
        CFG_INVERT_MASK:    invert_q    <= cfg_i.data.value[NUM_AXES-1:0];
        default: ;
      endcase
    end
  end

  ibrs_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ev_en_i (ev_en),
    .ev_i    (in_i.data.bus_event),
    .ctrl_o  (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.store) begin
      rx_store_q[ctrl.store_idx] <= in_i.data.rx_byte;
    end
  end

  // last byte is parsed straight from the input
  always_comb begin
    for (int i = 0; i < BURST_BYTES - 1; i++) begin
      frame[i] = rx_store_q[i];
    end
    frame[BURST_BYTES-1] = in_i.data.rx_byte;
  end

  ibrs_axis u_axis (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .parse_en_i  (ctrl.finish),
    .frame_i     (frame),
    .invert_i    (invert_q),
    .set_en_i    (set_en),
    .axis_i      (in_i.data.axis),
    .set_value_i (in_i.data.offset_value),
    .apply_i     (in_i.data.apply_offset),
    .rd_value_o  (rd_value)
  );

  always_comb begin
    busy_d = busy_q;
    out_d  = '0;
    unique case (in_i.data.cmd)
      CMD_START: begin
        out_d.bus_reset = busy_q;
        out_d.gen_start = 1'b1;
        busy_d          = 1'b1;
      end
      CMD_BUS_EVENT: begin
        out_d.send_valid = ctrl.send_sel != SEND_NONE;
        unique case (ctrl.send_sel)
          SEND_ADDR_W: out_d.send_byte = {dev_addr_q, 1'b0};
          SEND_REG:    out_d.send_byte = first_reg_q;
          SEND_ADDR_R: out_d.send_byte = {dev_addr_q, 1'b1};
          default:     out_d.send_byte = '0;
        endcase
        out_d.gen_start  = ctrl.gen_start;
        out_d.gen_stop   = ctrl.gen_stop;
        out_d.ack_ctrl   = ctrl.ack;
        out_d.frame_done = ctrl.finish;
        if (ctrl.finish) begin
          busy_d = 1'b0;
        end
      end
      CMD_SET_OFFSET: ;
      CMD_READ_AXIS: out_d.read_value = rd_value;
      default: ;
    endcase
    out_d.busy_res = busy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= busy_d;
      end
      if (in_i.ready) begin
        out_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  `IBRS_ASSERT(a_start_busy, clk_i, rst_ni, accept && in_i.data.cmd == CMD_START |=> busy_q, "start did not set busy")
  `IBRS_ASSERT(a_done_idle, clk_i, rst_ni, out_o.valid && out_o.data.frame_done |-> !out_o.data.busy_res, "busy after frame done")
  `IBRS_ASSERT(a_reset_start, clk_i, rst_ni, out_o.valid && out_o.data.bus_reset |-> out_o.data.gen_start, "bus reset without start")

endmodule

/* verif/tb_imu_burst_read_sequencer.sv */
// Self-checking testbench for the burst read sequencer, with a shadow of its state.
module tb_imu_burst_read_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import ibrs_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam logic [4:0] STEP_PARSE = STEP_LAST_ACK + 5'd1;

  // bus event order up to the first data byte
  localparam logic [2:0] HEAD_EVENTS [5] = '{EV_START, EV_TX_SEL, EV_TX_DONE, EV_START,
                                             EV_RX_SEL};
  // directed burst: max, min, zero, one and minus one among the axis words, temperature bytes in the middle
  localparam logic [7:0] EDGE_BYTES [BURST_BYTES] = '{8'hFF, 8'hFF, 8'h80, 8'h00, 8'h7F,
                                                      8'hFF, 8'hAA, 8'h55, 8'h00, 8'h00,
                                                      8'h00, 8'h01, 8'hC3, 8'h3C};

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_e;

  class burst_read_shadow;
    logic [6:0]  dev_addr;
    logic [7:0]  first_reg;
    logic [5:0]  inv_mask;
    logic [4:0]  step;
    logic [7:0]  rx_bytes [BURST_BYTES];
    logic [15:0] axis_word [NUM_AXES];
    logic [15:0] axis_trim [NUM_AXES];
    bit          busy;
    out_item_t   owed [$];
    int          errors;
    int          checked;

    function new();
      dev_addr  = DEV_ADDR_RESET;
      first_reg = FIRST_REG_RESET;
      inv_mask  = '0;
      step      = STEP_IDLE;
      busy      = 1'b0;
      errors    = 0;
      checked   = 0;
      foreach (rx_bytes[i]) rx_bytes[i] = '0;
      foreach (axis_word[i]) begin
        axis_word[i] = '0;
        axis_trim[i] = '0;
      end
    endfunction

    function void write_reg(cfg_item_t c);
      case (cfg_idx_e'(c.index))
        CFG_DEVICE_ADDRESS: dev_addr = c.value[6:0];
        CFG_FIRST_REGISTER: first_reg = c.value;
        CFG_INVERT_MASK:    inv_mask = c.value[5:0];
        default: ;
      endcase
    endfunction

    // six big-endian words, temperature word skipped
    function void parse_burst();
      int          p;
      logic [15:0] w;
      for (int i = 0; i < NUM_AXES; i++) begin
        p = (i < 3) ? 2 * i : 2 * i + 2;
        w = {rx_bytes[p], rx_bytes[p + 1]};
        if (inv_mask[i]) w = 16'h0000 - w;
        axis_word[i] = w;
        if (axis_trim[i] == 16'h0000) axis_trim[i] = w;
      end
    endfunction

    function void take_command(in_item_t it);
      out_item_t   r;
      logic [4:0]  was;
      logic [15:0] w;
      r = '0;
      case (it.cmd)
        CMD_START: begin
          r.bus_reset = busy;
          r.gen_start = 1'b1;
          busy = 1'b1;
        end
        CMD_BUS_EVENT: begin
          was = step;
          if (step == STEP_IDLE) begin
            if (it.bus_event == EV_START) begin
              r.send_valid = 1'b1;
              r.send_byte  = {dev_addr, 1'b0};
              step = 5'd2;
            end
          end else if (step == 5'd2) begin
            if (it.bus_event == EV_TX_SEL) begin
              r.send_valid = 1'b1;
              r.send_byte  = first_reg;
              step = 5'd3;
            end
          end else if (step == 5'd3) begin
            if (it.bus_event == EV_TX_DONE) begin
              r.gen_start = 1'b1;
              step = 5'd4;
            end
          end else if (step == 5'd4) begin
            if (it.bus_event == EV_START) begin
              r.send_valid = 1'b1;
              r.send_byte  = {dev_addr, 1'b1};
              step = 5'd5;
            end
          end else if (step == 5'd5) begin
            if (it.bus_event == EV_RX_SEL) begin
              r.ack_ctrl = ACK_ENABLE;
              step = STEP_FIRST_RX;
            end
          end else if (step >= STEP_FIRST_RX && step < STEP_PARSE) begin
            if (it.bus_event == EV_RX_BYTE) begin
              rx_bytes[step - STEP_FIRST_RX] = it.rx_byte;
              step = step + 5'd1;
              if (step == STEP_LAST_ACK) begin
                r.ack_ctrl = ACK_DISABLE;
                r.gen_stop = 1'b1;
              end
              if (step == STEP_PARSE) begin
                parse_burst();
                step = STEP_IDLE;
                busy = 1'b0;
                r.frame_done = 1'b1;
              end
            end
          end else begin
            step = STEP_IDLE;
          end
          // a start that did not move the sequence throws it back to idle
          if (step == was && it.bus_event == EV_START) step = STEP_IDLE;
        end
        CMD_SET_OFFSET: begin
          if (it.axis < NUM_AXES) axis_trim[it.axis] = it.offset_value;
          else if (it.axis == AXIS_EVERY)
            foreach (axis_trim[i]) axis_trim[i] = it.offset_value;
        end
        default: begin
          if (it.axis < NUM_AXES) begin
            w = axis_word[it.axis];
            if (it.apply_offset) w = w - axis_trim[it.axis];
            r.read_value = w;
          end
        end
      endcase
      r.busy_res = busy;
      owed.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 60) $display("mismatch at result %0d: %s", checked, msg);
      errors++;
    endtask

    task cmp(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %0h, expected %0h", field, got, want));
    endtask

    task match_response(out_item_t got);
      out_item_t want;
      if (owed.size() == 0) begin
        report("result with no item outstanding");
      end else begin
        want = owed.pop_front();
        cmp("send_valid", got.send_valid, want.send_valid);
        cmp("send_byte", got.send_byte, want.send_byte);
        cmp("gen_start", got.gen_start, want.gen_start);
        cmp("gen_stop", got.gen_stop, want.gen_stop);
        cmp("ack_ctrl", got.ack_ctrl, want.ack_ctrl);
        cmp("bus_reset", got.bus_reset, want.bus_reset);
        cmp("frame_done", got.frame_done, want.frame_done);
        cmp("read_value", got.read_value, want.read_value);
        cmp("busy_res", got.busy_res, want.busy_res);
      end
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  ibrs_in_if  in_ch ();
  ibrs_out_if out_ch ();
  ibrs_cfg_if cfg_ch ();

  imu_burst_read_sequencer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  burst_read_shadow shadow = new();

  int       items_sent = 0;
  int       burst_left = 0;
  bit       gaps_on = 1'b1;
  rx_mode_e rx_mode = RX_OPEN;
  bit [6:0] rx_age = '0;
  int       quiet = 0;

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  always #1 clk = ~clk;

  // result first: an item accepted now cannot have its result out on the same edge
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) shadow.match_response(out_ch.data);
    if (in_ch.valid && in_ch.ready) shadow.take_command(in_ch.data);
    if (cfg_ch.valid && cfg_ch.ready) shadow.write_reg(cfg_ch.data);
  end

  // receiver back-pressure in one of four modes, picked anew when the age counter runs out
  always @(posedge clk) begin
    if (rx_age == '0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_age  <= 7'($urandom_range(20, 120));
    end else begin
      rx_age <= rx_age - 7'd1;
    end
    case (rx_mode)
      RX_OPEN:     out_ch.ready <= 1'b1;
      RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 2) != 0);
      RX_PERIODIC: out_ch.ready <= (rx_age[1:0] == 2'b00);
      default:     out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet == QUIET_LIMIT) begin
      $display("tb_imu_burst_read_sequencer: FAIL");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [1:0] cmd, logic [2:0] ev, logic [7:0] rx,
                                  logic [2:0] axis, logic [15:0] offv, logic apply);
    in_item_t it;
    it.cmd          = cmd;
    it.bus_event    = ev;
    it.rx_byte      = rx;
    it.axis         = axis;
    it.offset_value = offv;
    it.apply_offset = apply;
    return it;
  endfunction

  function automatic in_item_t scramble();
    return mk(2'($urandom_range(0, 3)), 3'($urandom_range(0, 5)), 8'($urandom),
              3'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  task automatic push_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic set_regs(input logic [7:0] dev, input logic [7:0] reg_ptr,
                          input logic [7:0] inv);
    cfg_item_t c [3];
    c[0] = '{index: CFG_DEVICE_ADDRESS, value: dev};
    c[1] = '{index: CFG_FIRST_REGISTER, value: reg_ptr};
    c[2] = '{index: CFG_INVERT_MASK, value: inv};
    for (int i = 0; i < 3; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data  <= c[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // stop sending and let every outstanding result drain
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (shadow.owed.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic directed();
    push_item(mk(CMD_SET_OFFSET, EV_NONE, 8'h00, 3'd7, 16'h7FFF, 1'b0));
    push_item(mk(CMD_SET_OFFSET, EV_NONE, 8'h00, AXIS_EVERY, 16'h8000, 1'b0));
    push_item(mk(CMD_SET_OFFSET, EV_NONE, 8'h00, 3'd2, 16'h0000, 1'b0));
    push_item(mk(CMD_START, EV_NONE, 8'h00, 3'd0, 16'h0000, 1'b0));
    push_item(mk(CMD_START, EV_NONE, 8'h00, 3'd0, 16'h0000, 1'b0));  // busy: bus reset
    push_item(mk(CMD_BUS_EVENT, EV_NONE, 8'h00, 3'd0, 16'h0000, 1'b0));
    push_item(mk(CMD_BUS_EVENT, EV_START, 8'h00, 3'd0, 16'h0000, 1'b0));
    push_item(mk(CMD_BUS_EVENT, EV_START, 8'h00, 3'd0, 16'h0000, 1'b0));  // stray start
    for (int j = 0; j < 5; j++)
      push_item(mk(CMD_BUS_EVENT, HEAD_EVENTS[j], 8'h00, 3'd0, 16'h0000, 1'b0));
    for (int j = 0; j < BURST_BYTES; j++)
      push_item(mk(CMD_BUS_EVENT, EV_RX_BYTE, EDGE_BYTES[j], 3'd0, 16'h0000, 1'b0));
    push_item(mk(CMD_READ_AXIS, EV_NONE, 8'h00, 3'd2, 16'h0000, 1'b1));
    push_item(mk(CMD_READ_AXIS, EV_NONE, 8'h00, 3'd0, 16'h0000, 1'b1));
  endtask

  function automatic in_item_t side_item();
    in_item_t it;
    it = scramble();
    if ($urandom_range(0, 4) < 3) begin
      it.cmd = CMD_READ_AXIS;
    end else begin
      it.cmd = CMD_SET_OFFSET;
      if ($urandom_range(0, 3) == 0) it.offset_value = '0;
    end
    return it;
  endfunction

  // one burst read with random data, side commands and the odd fault mixed in
  task automatic burst_read();
    in_item_t it;
    int       r;
    if ($urandom_range(0, 9) != 0) begin
      it = scramble();
      it.cmd = CMD_START;
      push_item(it);
    end
    for (int j = 0; j < 5 + BURST_BYTES; j++) begin
      while ($urandom_range(0, 5) == 0) push_item(side_item());
      r = $urandom_range(0, 99);
      if (r < 2) return;  // abandoned: the next start finds the bus busy
      if (r < 5) begin
        it = scramble();
        it.cmd = CMD_BUS_EVENT;
        push_item(it);
      end
      it = scramble();
      it.cmd = CMD_BUS_EVENT;
      it.bus_event = (j < 5) ? HEAD_EVENTS[j] : EV_RX_BYTE;
      push_item(it);
    end
  endtask

  task automatic run_traffic(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(0, 99) < 8) push_item(scramble());
      else burst_read();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_regs({1'b0, DEV_ADDR_RESET}, FIRST_REG_RESET, 8'h00);
    directed();
    settle();
    gaps_on = 1'b1;
    run_traffic(470);
    settle();

    set_regs(8'h00, 8'h00, 8'h3F);
    gaps_on = 1'b0;
    run_traffic(470);
    settle();

    set_regs(8'hFF, 8'hFF, 8'h15);
    gaps_on = 1'b1;
    run_traffic(470);
    settle();

    set_regs(8'($urandom), 8'($urandom), 8'($urandom));
    run_traffic(470);
    settle();

    if (shadow.errors == 0) begin
      $display("tb_imu_burst_read_sequencer: PASS");
    end else begin
      $display("tb_imu_burst_read_sequencer: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/ibrs_pkg.sv
rtl/ibrs_if.sv
rtl/ibrs_seq.sv
rtl/ibrs_axis.sv
rtl/imu_burst_read_sequencer.sv
verif/tb_imu_burst_read_sequencer.sv
